>>> rtl/flh_pkg.sv
`timescale 1ns / 1ps

package flh_pkg;

   // Grid geometry; both sides are powers of two so a cell address is {z, x}
   localparam int MAX_LENGTH = 64;
   localparam int MAX_WIDTH  = 64;
   localparam int XW         = $clog2(MAX_LENGTH);
   localparam int ZW         = $clog2(MAX_WIDTH);
   localparam int ADDR_W     = XW + ZW;
   localparam int DEPTH      = MAX_LENGTH * MAX_WIDTH;

   // Field widths
   localparam int SIZE_W   = 7;
   localparam int HEIGHT_W = 16;
   localparam int COEF_W   = 16;
   localparam int OFS_W    = 22;
   localparam int COUNT_W  = 16;
   localparam int TYPE_W   = 2;

   // Line test accumulator: |a*x| + |b*z| + |c| stays below 2^(ACC_W-1)
   localparam int ACC_W = COEF_W + XW + 2;

   // Request stream packing
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 32;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_LENGTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_HEIGHT = 2'd2;

   // Request kinds
   localparam logic [TYPE_W-1:0] REQ_APPLY = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_READ  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_INIT  = 2'd2;

   // Height limits
   localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 16'sh7fff;
   localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = 16'sh8000;

endpackage

>>> rtl/fault_line_heightmap_unit.sv
`timescale 1ns / 1ps

// Channel  | Ports                              | Contents (lowest bit first)
// ---------+------------------------------------+----------------------------------------
// request  | req_tvalid req_tready req_tdata    | tdata: line_cos, line_sin, line_offset,
//          | req_tuser                          |        cell_x, cell_z; tuser: req_type
// response | rsp_tvalid rsp_tready rsp_tdata    | tdata: cell_height, lines_applied
//          | rsp_tuser                          | tuser: out_of_range
// csr      | csr_wr_en csr_index csr_wdata      | grid_length, grid_width, initial_height
//
// Apply sweeps the length*width cells one per cycle through the single read
// port and single write port of the height memory. Init sweeps all 4096 cells.
// After reset a fill writes initial_height to every cell; requests wait for it,
// csr writes are taken. One request is in work at a time; a finished response
// may wait in the output register while the next is taken.

module fault_line_heightmap_unit (
   input  logic                             clock,
   input  logic                             reset,
   // request
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // line_cos[15:0], line_sin[31:16], line_offset[53:32], cell_x[59:54], cell_z[65:60]
   input  logic [flh_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type[1:0]
   input  logic [flh_pkg::TYPE_W-1:0]       req_tuser,
   // response
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // cell_height[15:0], lines_applied[31:16]
   output logic [flh_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // out_of_range[0]
   output logic                             rsp_tuser,
   // configuration
   input  logic                             csr_wr_en,
   input  logic [flh_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [flh_pkg::HEIGHT_W-1:0]     csr_wdata
);
   import flh_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_APPLY,
      ST_READ,
      ST_FINISH
   } state_type;

   state_type                    state_ff;

   // configuration registers
   logic [SIZE_W-1:0]            grid_length_ff;
   logic [SIZE_W-1:0]            grid_width_ff;
   logic signed [HEIGHT_W-1:0]   initial_height_ff;

   // request fields
   logic signed [COEF_W-1:0]     req_cos;
   logic signed [COEF_W-1:0]     req_sin;
   logic signed [OFS_W-1:0]      req_offset;
   logic [XW-1:0]                req_x;
   logic [ZW-1:0]                req_z;

   // sweep state
   logic signed [COEF_W-1:0]     a_ff;
   logic signed [COEF_W-1:0]     b_ff;
   logic signed [ACC_W-1:0]      acc_ff;
   logic signed [ACC_W-1:0]      row_ff;
   logic signed [ACC_W-1:0]      row_step;
   logic signed [ACC_W-1:0]      neg_offset;
   logic [XW-1:0]                x_ff;
   logic [ZW-1:0]                z_ff;
   logic [ADDR_W-1:0]            clr_addr_ff;
   logic                         clr_rsp_ff;
   logic [SIZE_W-1:0]            len_eff;
   logic [SIZE_W-1:0]            wid_eff;
   logic                         last_x;
   logic                         last_z;
   logic                         req_oor;

   // write-back stage
   logic                         wb_valid_ff;
   logic                         wb_up_ff;
   logic [ADDR_W-1:0]            wb_addr_ff;

   // result
   logic [COUNT_W-1:0]           count_ff;
   logic signed [HEIGHT_W-1:0]   res_height_ff;
   logic                         res_oor_ff;
   logic                         rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]        rsp_tdata_ff;
   logic                         rsp_tuser_ff;

   // memory ports
   logic signed [HEIGHT_W-1:0]   height_mem [DEPTH];
   logic signed [HEIGHT_W-1:0]   rd_data_ff;
   logic [ADDR_W-1:0]            mem_ra;
   logic                         mem_we;
   logic [ADDR_W-1:0]            mem_wa;
   logic signed [HEIGHT_W-1:0]   mem_wd;
   logic signed [HEIGHT_W-1:0]   wb_height;

   // unpack request
   assign req_cos    = req_tdata[15:0];
   assign req_sin    = req_tdata[31:16];
   assign req_offset = req_tdata[53:32];
   assign req_x      = req_tdata[59:54];
   assign req_z      = req_tdata[65:60];

   // clamp grid size to 1..max
   always_comb begin
      if (grid_length_ff == '0)
         len_eff = SIZE_W'(1);
      else if (grid_length_ff > SIZE_W'(MAX_LENGTH))
         len_eff = SIZE_W'(MAX_LENGTH);
      else
         len_eff = grid_length_ff;
      if (grid_width_ff == '0)
         wid_eff = SIZE_W'(1);
      else if (grid_width_ff > SIZE_W'(MAX_WIDTH))
         wid_eff = SIZE_W'(MAX_WIDTH);
      else
         wid_eff = grid_width_ff;
   end

   assign last_x  = (SIZE_W'(x_ff) == len_eff - SIZE_W'(1));
   assign last_z  = (SIZE_W'(z_ff) == wid_eff - SIZE_W'(1));
   assign req_oor = (SIZE_W'(req_x) >= len_eff) || (SIZE_W'(req_z) >= wid_eff);

   assign neg_offset = -{{(ACC_W-OFS_W){req_offset[OFS_W-1]}}, req_offset};
   assign row_step   = row_ff + {{(ACC_W-COEF_W){b_ff[COEF_W-1]}}, b_ff};

   // select read address: sweep cell or requested cell
   always_comb begin
      case (state_ff)
         ST_APPLY: mem_ra = {z_ff, x_ff};
         default:  mem_ra = {req_z, req_x};
      endcase
   end

   // step the height one unit with saturation
   always_comb begin
      if (wb_up_ff)
         wb_height = (rd_data_ff == HEIGHT_MAX) ? rd_data_ff : rd_data_ff + 16'sd1;
      else
         wb_height = (rd_data_ff == HEIGHT_MIN) ? rd_data_ff : rd_data_ff - 16'sd1;
   end

   // write port: fill sweep or apply write-back
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
         mem_wa = clr_addr_ff;
         mem_wd = initial_height_ff;
      end else begin
         mem_we = wb_valid_ff;
         mem_wa = wb_addr_ff;
         mem_wd = wb_height;
      end
   end

   // height memory, one read and one write port
   always_ff @(posedge clock) begin
      if (mem_we)
         height_mem[mem_wa] <= mem_wd;
      rd_data_ff <= height_mem[mem_ra];
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_length_ff    <= SIZE_W'(MAX_LENGTH);
         grid_width_ff     <= SIZE_W'(MAX_WIDTH);
         initial_height_ff <= 16'sd1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GRID_LENGTH:    grid_length_ff    <= csr_wdata[SIZE_W-1:0];
            CSR_GRID_WIDTH:     grid_width_ff     <= csr_wdata[SIZE_W-1:0];
            CSR_INITIAL_HEIGHT: initial_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         clr_rsp_ff    <= 1'b0;
         wb_valid_ff   <= 1'b0;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         wb_valid_ff <= 1'b0;
         // drop a taken response unless the next one loads now
         if (rsp_tvalid_ff && rsp_tready && state_ff != ST_FINISH)
            rsp_tvalid_ff <= 1'b0;

         case (state_ff)
            ST_CLEAR: begin
               if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
                  state_ff   <= clr_rsp_ff ? ST_FINISH : ST_IDLE;
                  clr_rsp_ff <= 1'b0;
               end
               clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
            end

            ST_IDLE: begin
               if (req_tvalid) begin
                  res_height_ff <= '0;
                  res_oor_ff    <= 1'b0;
                  case (req_tuser)
                     REQ_APPLY: begin
                        a_ff     <= req_cos;
                        b_ff     <= req_sin;
                        acc_ff   <= neg_offset;
                        row_ff   <= neg_offset;
                        x_ff     <= '0;
                        z_ff     <= '0;
                        count_ff <= count_ff + COUNT_W'(1);
                        state_ff <= ST_APPLY;
                     end
                     REQ_READ: begin
                        res_oor_ff <= req_oor;
                        state_ff   <= req_oor ? ST_FINISH : ST_READ;
                     end
                     REQ_INIT: begin
                        count_ff    <= '0;
                        clr_addr_ff <= '0;
                        clr_rsp_ff  <= 1'b1;
                        state_ff    <= ST_CLEAR;
                     end
                     default: state_ff <= ST_FINISH;
                  endcase
               end
            end

            ST_APPLY: begin
               // hand the cell to write-back, advance along x then z
               wb_valid_ff <= 1'b1;
               wb_addr_ff  <= {z_ff, x_ff};
               wb_up_ff    <= (acc_ff > 0);
               if (last_x) begin
                  x_ff   <= '0;
                  z_ff   <= z_ff + ZW'(1);
                  row_ff <= row_step;
                  acc_ff <= row_step;
                  if (last_z)
                     state_ff <= ST_FINISH;
               end else begin
                  x_ff   <= x_ff + XW'(1);
                  acc_ff <= acc_ff + {{(ACC_W-COEF_W){a_ff[COEF_W-1]}}, a_ff};
               end
            end

            ST_READ: begin
               res_height_ff <= rd_data_ff;
               state_ff      <= ST_FINISH;
            end

            ST_FINISH: begin
               // load the response once the output register is free
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {count_ff, res_height_ff};
                  rsp_tuser_ff  <= res_oor_ff;
                  state_ff      <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

>>> rtl/flh_checker.sv
`timescale 1ns / 1ps

module flh_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [flh_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                             rsp_tuser
);
   import flh_pkg::*;

   // fill sweep runs after reset, so no request is taken right away
   a_fill_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("request taken or response shown right after reset");

   // one request in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in work");

   // with no response shown, a taken request brings none until the sequencer has passed ST_FINISH
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response appeared one cycle after a request");

   // out-of-range reads carry zero height
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[HEIGHT_W-1:0] == '0)
      else $error("out-of-range read carries a height");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

endmodule

bind fault_line_heightmap_unit flh_checker u_flh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
